[rtl/p80_pkg.sv]
// ----------------------------------------------------------------------------
// p80_pkg: shared types and functions for the PRESENT-80 cipher core
// Holds the S-box tables, bit permutations, key schedule steps, the
// register index codes and the control struct that drives the datapath.
// ----------------------------------------------------------------------------
package p80_pkg;

  localparam int BLOCK_W     = 64;
  localparam int KEY_W       = 80;
  localparam int KEY_HIGH_W  = 16;
  localparam int RND_W       = 5;
  localparam int ROUND_COUNT = 31;
  localparam int CFG_ADDR_W  = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_type_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             key_only;
    logic             decrypt;
    logic [RND_W-1:0] rnd;
  } p80_ctrl_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h5;
      4'h1: y = 4'hE;
      4'h2: y = 4'hF;
      4'h3: y = 4'h8;
      4'h4: y = 4'hC;
      4'h5: y = 4'h1;
      4'h6: y = 4'h2;
      4'h7: y = 4'hD;
      4'h8: y = 4'hB;
      4'h9: y = 4'h4;
      4'hA: y = 4'h6;
      4'hB: y = 4'h3;
      4'hC: y = 4'h0;
      4'hD: y = 4'h7;
      4'hE: y = 4'h9;
      default: y = 4'hA;
    endcase
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      y[4*n +: 4] = sbox_fwd(x[4*n +: 4]);
    end
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      y[4*n +: 4] = sbox_inv(x[4*n +: 4]);
    end
    return y;
  endfunction

  // Bit i moves to bit (16*i mod 63); bit 63 stays in place.
  function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    y[BLOCK_W-1] = x[BLOCK_W-1];
    for (int i = 0; i < BLOCK_W - 1; i++) begin
      y[(i * 16) % (BLOCK_W - 1)] = x[i];
    end
    return y;
  endfunction

  // Bit i moves to bit (4*i mod 63); bit 63 stays in place.
  function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    y[BLOCK_W-1] = x[BLOCK_W-1];
    for (int i = 0; i < BLOCK_W - 1; i++) begin
      y[(i * 4) % (BLOCK_W - 1)] = x[i];
    end
    return y;
  endfunction

  // Forward key update: rotate left by 61, S-box on the top nibble,
  // round counter into bits 19..15.
  function automatic logic [KEY_W-1:0] key_fwd(input logic [KEY_W-1:0] k,
                                               input logic [RND_W-1:0] r);
    logic [KEY_W-1:0] t;
    t = {k[18:0], k[79:19]};
    t[79:76] = sbox_fwd(t[79:76]);
    t[19:15] = t[19:15] ^ r;
    return t;
  endfunction

  // Exact inverse of key_fwd for the same counter value.
  function automatic logic [KEY_W-1:0] key_inv(input logic [KEY_W-1:0] k,
                                               input logic [RND_W-1:0] r);
    logic [KEY_W-1:0] t;
    t = k;
    t[19:15] = t[19:15] ^ r;
    t[79:76] = sbox_inv(t[79:76]);
    return {t[60:0], t[79:61]};
  endfunction

endpackage

[rtl/p80_datapath.sv]
// ----------------------------------------------------------------------------
// p80_datapath: shared round unit of the PRESENT-80 core
// Holds the cipher state and the running key register. Each step applies
// one encryption round, one decryption round, or a key schedule step alone.
// ----------------------------------------------------------------------------
module p80_datapath (
  input  logic                          clk,
  input  p80_pkg::p80_ctrl_t            ctrl,
  input  logic [p80_pkg::BLOCK_W-1:0]   block_in,
  input  logic [p80_pkg::KEY_W-1:0]     key_in,
  output logic [p80_pkg::BLOCK_W-1:0]   block_out
);

  logic [p80_pkg::BLOCK_W-1:0] state_r;
  logic [p80_pkg::BLOCK_W-1:0] state_nxt;
  logic [p80_pkg::KEY_W-1:0]   key_r;
  logic [p80_pkg::KEY_W-1:0]   key_nxt;
  logic [p80_pkg::BLOCK_W-1:0] mixed;

  assign mixed = state_r ^ key_r[p80_pkg::KEY_W-1 -: p80_pkg::BLOCK_W];

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    if (ctrl.load) begin
      state_nxt = block_in;
      key_nxt   = key_in;
    end else if (ctrl.step) begin
      if (ctrl.key_only) begin
        key_nxt = p80_pkg::key_fwd(key_r, ctrl.rnd);
      end else if (ctrl.decrypt) begin
        state_nxt = p80_pkg::sub_inv(p80_pkg::perm_inv(mixed));
        key_nxt   = p80_pkg::key_inv(key_r, ctrl.rnd);
      end else begin
        state_nxt = p80_pkg::perm_fwd(p80_pkg::sub_fwd(mixed));
        key_nxt   = p80_pkg::key_fwd(key_r, ctrl.rnd);
      end
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    key_r   <= key_nxt;
  end

  assign block_out = mixed;

endmodule

[rtl/present80_block_cipher_core.sv]
// ----------------------------------------------------------------------------
// present80_block_cipher_core: PRESENT-80 encrypt/decrypt core
// The 80-bit key is loaded through the configuration port: index 0 writes
// key bits 63..0, index 1 writes key bits 79..64. Write it only while idle.
// A request on the in_ stream carries the 64-bit block in in_tdata and the
// request type in in_tuser (0 encrypts, 1 decrypts). One request gives one
// result on the out_ stream.
// One shared round unit does one round per cycle. Encryption runs
// ROUND_COUNT rounds, then applies the final key XOR as the result enters
// the output register. Decryption first runs the key schedule forward to
// reach the last round key, then runs the rounds backward while stepping
// the schedule in reverse, and ends with a final key XOR as well.
// in_tready is high only while the core is idle, so one request is in flight
// at a time. The result sits in an output register; a new request is taken
// while it waits. If the receiver stalls and a second result is ready, the
// core holds it until the output register frees.
// Reset clears both key registers, the sequencer and out_tvalid.
// ----------------------------------------------------------------------------
module present80_block_cipher_core #(
  parameter int ROUND_COUNT = p80_pkg::ROUND_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [p80_pkg::BLOCK_W-1:0]       in_tdata,   // [63:0] block_in
  input  logic                              in_tuser,   // [0] req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [p80_pkg::BLOCK_W-1:0]       out_tdata,  // [63:0] block_out
  input  logic                              cfg_we,
  input  logic [p80_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [p80_pkg::BLOCK_W-1:0]       cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_KEYS   = 4'b0010,
    ST_ROUNDS = 4'b0100,
    ST_FINAL  = 4'b1000
  } state_t;

  localparam logic [p80_pkg::RND_W-1:0] LAST_RND = p80_pkg::RND_W'(ROUND_COUNT);
  localparam logic [p80_pkg::RND_W-1:0] FIRST_RND = p80_pkg::RND_W'(1);

  state_t                                   state_r, state_nxt;
  logic [p80_pkg::RND_W-1:0]                rnd_r, rnd_nxt;
  logic                                     decrypt_r, decrypt_nxt;
  logic [p80_pkg::BLOCK_W-1:0]              key_low_r;
  logic [p80_pkg::KEY_HIGH_W-1:0]           key_high_r;
  logic                                     out_valid_r, out_valid_nxt;
  logic [p80_pkg::BLOCK_W-1:0]              out_data_r;
  logic                                     in_req;
  logic                                     out_free;
  logic                                     out_load;
  logic [p80_pkg::BLOCK_W-1:0]              dp_result;
  p80_pkg::p80_ctrl_t                       ctrl;

  assign in_tready = (state_r == ST_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == ST_FINAL) && out_free;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    decrypt_nxt   = decrypt_r;
    ctrl.load     = 1'b0;
    ctrl.step     = 1'b0;
    ctrl.key_only = 1'b0;
    ctrl.decrypt  = decrypt_r;
    ctrl.rnd      = rnd_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          ctrl.load   = 1'b1;
          decrypt_nxt = (in_tuser == p80_pkg::REQ_DECRYPT);
          rnd_nxt     = FIRST_RND;
          state_nxt   = (in_tuser == p80_pkg::REQ_DECRYPT) ? ST_KEYS : ST_ROUNDS;
        end
      end
      ST_KEYS: begin
        ctrl.step     = 1'b1;
        ctrl.key_only = 1'b1;
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_ROUNDS;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      ST_ROUNDS: begin
        ctrl.step = 1'b1;
        if (decrypt_r) begin
          if (rnd_r == FIRST_RND) begin
            state_nxt = ST_FINAL;
          end else begin
            rnd_nxt = rnd_r - 1'b1;
          end
        end else begin
          if (rnd_r == LAST_RND) begin
            state_nxt = ST_FINAL;
          end else begin
            rnd_nxt = rnd_r + 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= FIRST_RND;
      decrypt_r   <= 1'b0;
      out_valid_r <= 1'b0;
      key_low_r   <= '0;
      key_high_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      decrypt_r   <= decrypt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          p80_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
          p80_pkg::CFG_KEY_HIGH: key_high_r <= cfg_wdata[p80_pkg::KEY_HIGH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= dp_result;
    end
  end

  p80_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .block_in  (in_tdata),
    .key_in    ({key_high_r, key_low_r}),
    .block_out (dp_result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[dv/p80_block_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// p80_block_scoreboard_pkg: block predictor and result checker
// Keeps a private copy of the 80-bit key, expands it into the round keys,
// and predicts the PRESENT-80 encryption or decryption of every accepted
// request. Predicted blocks wait in order and each result is checked against
// the oldest one.
// ----------------------------------------------------------------------------
package p80_block_scoreboard_pkg;

  // S-box tables, entry 0 in the top nibble.
  localparam logic [63:0] FWD_SBOX = 64'hC56B90AD3EF84712;
  localparam logic [63:0] INV_SBOX = 64'h5EF8C12DB463079A;

  class p80_block_scoreboard;

    logic [p80_pkg::KEY_W-1:0]   cipher_key;
    logic [p80_pkg::BLOCK_W-1:0] subkey [0:p80_pkg::ROUND_COUNT];
    logic [p80_pkg::BLOCK_W-1:0] expected_blocks [$];
    int unsigned                 mismatches;
    int unsigned                 results_checked;
    int unsigned                 encrypt_count;
    int unsigned                 decrypt_count;

    function new();
      cipher_key      = '0;
      mismatches      = 0;
      results_checked = 0;
      encrypt_count   = 0;
      decrypt_count   = 0;
      schedule_keys();
    endfunction

    function logic [3:0] look_up(logic [63:0] lut, logic [3:0] nib);
      return lut[4 * (15 - int'(nib)) +: 4];
    endfunction

    function logic [p80_pkg::BLOCK_W-1:0] substitute(logic [p80_pkg::BLOCK_W-1:0] x,
                                                     logic [63:0] lut);
      logic [p80_pkg::BLOCK_W-1:0] y;
      for (int n = 0; n < 16; n++) begin
        y[4*n +: 4] = look_up(lut, x[4*n +: 4]);
      end
      return y;
    endfunction

    function logic [p80_pkg::BLOCK_W-1:0] scatter_bits(logic [p80_pkg::BLOCK_W-1:0] x,
                                                       int mult);
      logic [p80_pkg::BLOCK_W-1:0] y;
      y[63] = x[63];
      for (int i = 0; i < 63; i++) begin
        y[(i * mult) % 63] = x[i];
      end
      return y;
    endfunction

    function void schedule_keys();
      logic [p80_pkg::KEY_W-1:0] k;
      k = cipher_key;
      subkey[0] = k[79:16];
      for (int r = 1; r <= p80_pkg::ROUND_COUNT; r++) begin
        k = {k[18:0], k[79:19]};
        k[79:76] = look_up(FWD_SBOX, k[79:76]);
        k[19:15] = k[19:15] ^ 5'(r);
        subkey[r] = k[79:16];
      end
    endfunction

    function void write_key(p80_pkg::cfg_reg_t idx, logic [p80_pkg::BLOCK_W-1:0] value);
      case (idx)
        p80_pkg::CFG_KEY_LOW:  cipher_key[63:0]  = value;
        p80_pkg::CFG_KEY_HIGH: cipher_key[79:64] = value[p80_pkg::KEY_HIGH_W-1:0];
        default: ;
      endcase
      schedule_keys();
    endfunction

    function logic [p80_pkg::BLOCK_W-1:0] encipher(logic [p80_pkg::BLOCK_W-1:0] blk);
      logic [p80_pkg::BLOCK_W-1:0] s;
      s = blk;
      for (int r = 0; r < p80_pkg::ROUND_COUNT; r++) begin
        s = scatter_bits(substitute(s ^ subkey[r], FWD_SBOX), 16);
      end
      return s ^ subkey[p80_pkg::ROUND_COUNT];
    endfunction

    function logic [p80_pkg::BLOCK_W-1:0] decipher(logic [p80_pkg::BLOCK_W-1:0] blk);
      logic [p80_pkg::BLOCK_W-1:0] s;
      s = blk;
      for (int r = p80_pkg::ROUND_COUNT; r > 0; r--) begin
        s = substitute(scatter_bits(s ^ subkey[r], 4), INV_SBOX);
      end
      return s ^ subkey[0];
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    function void note_request(p80_pkg::req_type_t req, logic [p80_pkg::BLOCK_W-1:0] blk);
      if (req == p80_pkg::REQ_DECRYPT) begin
        expected_blocks.push_back(decipher(blk));
        decrypt_count++;
      end else begin
        expected_blocks.push_back(encipher(blk));
        encrypt_count++;
      end
    endfunction

    task report(string what, logic [p80_pkg::BLOCK_W-1:0] got,
                logic [p80_pkg::BLOCK_W-1:0] want);
      mismatches++;
      $display("[%0t] mismatch: %s, got %016h, expected %016h", $realtime, what, got, want);
    endtask

    task check_result(logic [p80_pkg::BLOCK_W-1:0] got);
      logic [p80_pkg::BLOCK_W-1:0] want;
      results_checked++;
      if (expected_blocks.size() == 0) begin
        report("result with no request outstanding", got, '0);
      end else begin
        want = expected_blocks.pop_front();
        if (got !== want) begin
          report("block_out", got, want);
        end
      end
    endtask

  endclass

endpackage

[dv/tb_present80_block_cipher_core.sv]
// ----------------------------------------------------------------------------
// tb_present80_block_cipher_core: testbench for the PRESENT-80 cipher core
// Runs directed and random encrypt and decrypt requests under several keys,
// including all-zero and all-one keys, with random idle cycles on both
// streams and one long receiver stall. Every result is compared with the
// scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_present80_block_cipher_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 2 * p80_pkg::ROUND_COUNT + 8;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [p80_pkg::BLOCK_W-1:0]    in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [p80_pkg::BLOCK_W-1:0]    out_tdata;
  logic                           cfg_we;
  logic [p80_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [p80_pkg::BLOCK_W-1:0]    cfg_wdata;

  p80_block_scoreboard_pkg::p80_block_scoreboard sb = new();

  bit pace_on = 1'b1;
  bit hold_request = 1'b0;
  bit run_done = 1'b0;
  int key_settings = 1;
  int stall_cycles = 0;

  present80_block_cipher_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_request(p80_pkg::req_type_t'(in_tuser), in_tdata);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || run_done || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random stalls per result, and one long hold on demand.
  initial begin
    int wait_cycles;
    out_tready = 1'b0;
    forever begin
      wait_cycles = pace_on ? $urandom_range(0, 5) : 0;
      if (hold_request) begin
        wait_cycles  = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_tready = 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task write_cfg(p80_pkg::cfg_reg_t idx, logic [p80_pkg::BLOCK_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    sb.write_key(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_block(p80_pkg::req_type_t req, logic [p80_pkg::BLOCK_W-1:0] blk);
    int gap;
    gap = pace_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = blk;
    in_tuser  = req;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task send_random(int count);
    p80_pkg::req_type_t          req;
    logic [p80_pkg::BLOCK_W-1:0] blk;
    int                          pick;
    for (int n = 0; n < count; n++) begin
      req  = p80_pkg::req_type_t'($urandom_range(0, 1));
      blk  = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      case (pick)
        6: begin
          blk = 64'd1 << $urandom_range(0, 63);
          if ($urandom_range(0, 1) == 1) blk = ~blk;
        end
        7: begin
          req = p80_pkg::REQ_DECRYPT;
          blk = sb.encipher(blk);
        end
        8: begin
          req = p80_pkg::REQ_ENCRYPT;
          blk = sb.decipher(blk);
        end
        9: blk = ($urandom_range(0, 1) == 1) ? '1 : '0;
        default: ;
      endcase
      send_block(req, blk);
    end
  endtask

  task settle();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task load_key(logic [p80_pkg::BLOCK_W-1:0] high_word,
                logic [p80_pkg::BLOCK_W-1:0] low_word);
    write_cfg(p80_pkg::CFG_KEY_LOW, low_word);
    write_cfg(p80_pkg::CFG_KEY_HIGH, high_word);
    key_settings++;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = p80_pkg::REQ_ENCRYPT;
    cfg_we    = 1'b0;
    cfg_addr  = p80_pkg::CFG_KEY_LOW;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // All-zero key straight out of reset.
    send_block(p80_pkg::REQ_ENCRYPT, 64'h0);
    send_block(p80_pkg::REQ_ENCRYPT, '1);
    send_block(p80_pkg::REQ_DECRYPT, 64'h0);
    send_block(p80_pkg::REQ_DECRYPT, '1);
    send_block(p80_pkg::REQ_ENCRYPT, 64'h8000_0000_0000_0000);
    send_block(p80_pkg::REQ_DECRYPT, 64'h0000_0000_0000_0001);
    send_block(p80_pkg::REQ_DECRYPT, sb.encipher(64'h0123_4567_89AB_CDEF));
    send_block(p80_pkg::REQ_ENCRYPT, sb.decipher(64'hFEDC_BA98_7654_3210));
    send_random(235);
    settle();

    // All-one key; the high write carries set bits above the register width.
    load_key('1, '1);
    send_block(p80_pkg::REQ_ENCRYPT, 64'h0);
    send_block(p80_pkg::REQ_ENCRYPT, '1);
    send_block(p80_pkg::REQ_DECRYPT, 64'h0);
    send_block(p80_pkg::REQ_DECRYPT, '1);
    send_block(p80_pkg::REQ_ENCRYPT, 64'h5555_5555_5555_5555);
    send_block(p80_pkg::REQ_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_random(235);
    settle();

    load_key(64'h8000, 64'h1);
    send_block(p80_pkg::REQ_ENCRYPT, 64'h0);
    send_block(p80_pkg::REQ_DECRYPT, 64'h0);
    send_random(235);
    settle();

    pace_on = 1'b0;
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    send_random(235);
    settle();
    pace_on = 1'b1;

    hold_request = 1'b1;
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    send_random(235);
    settle();

    write_cfg(p80_pkg::CFG_KEY_LOW, {$urandom, $urandom});
    key_settings++;
    send_random(235);
    settle();

    load_key(64'hFFFF, 64'h0);
    send_block(p80_pkg::REQ_ENCRYPT, 64'h0);
    send_block(p80_pkg::REQ_DECRYPT, '1);
    send_random(235);
    settle();

    repeat (DRAIN_WAIT) @(posedge clk);
    run_done = 1'b1;

    $display("Covered %0d encryptions and %0d decryptions under %0d keys; %0d results checked.",
             sb.encrypt_count, sb.decrypt_count, key_settings, sb.results_checked);
    $display("Included a %0d-cycle receiver hold and a stretch with no idle cycles.",
             LONG_HOLD);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
